FILE: src/brush_dab_placement_macros.svh
// Assertion macros used by the brush dab placement top module.
`ifndef BRUSH_DAB_PLACEMENT_MACROS_SVH
`define BRUSH_DAB_PLACEMENT_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent in a cycle implies the consequent in the same cycle.
`define BDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brush dab placement check failed");
// Condition holds at every clock edge outside reset.
`define BDP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("brush dab placement invariant failed");
`else
`define BDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BDP_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

FILE: src/bdp_pkg.sv
package bdp_pkg;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQS, ST_SQRT, ST_CHK, ST_SZP, ST_JIT, ST_JH,
        ST_JS, ST_ANG, ST_ANGW, ST_PX, ST_DXS, ST_DXW, ST_PY, ST_DYS, ST_DYW,
        ST_STEP, ST_EMIT, ST_FIN
    } t_state;

    // Operations of the iterative root and divide unit.
    typedef enum logic {
        ITU_SQRT,
        ITU_DIV
    } t_itu_op;

    typedef struct packed {
        logic    start;
        t_itu_op op;
    } t_itu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_itu_stat;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SPACING   = 3'd0;
    localparam logic [2:0] CFG_BASE_SIZE = 3'd1;
    localparam logic [2:0] CFG_SIZE_PRS  = 3'd2;
    localparam logic [2:0] CFG_ALPHA_PRS = 3'd3;
    localparam logic [2:0] CFG_ANG_JIT   = 3'd4;
    localparam logic [2:0] CFG_SIZE_JIT  = 3'd5;

    // Noise generator seed and tap mask.
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // Both root and quotient have 17 result bits.
    localparam logic [4:0] ITU_LAST = 5'd16;

endpackage

FILE: src/brush_dab_placement.sv
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_ready     | start, end, carry, pressure
// out     | output    | o_out_valid / i_out_ready   | kind, dab fields, carry, cut, last
// cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A segment takes setup and a square root, then per dab shared multiplies and two
// divisions, and finally the leftover item; a zero-length segment emits no item.
// The iterative root and divide unit computes one result bit per cycle.
// Reset is synchronous and active low; it restores the register defaults and seed.
// The input is not ready until the leftover item is loaded into the output register or a zero-length segment ends.
// A stalled output holds the sequencer at its emit or finish step.
module brush_dab_placement import bdp_pkg::*; #(
    parameter int MAX_DABS   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_end_x,
    input  logic [15:0] i_end_y,
    input  logic [15:0] i_carry_in,
    input  logic [8:0]  i_pressure,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [15:0] o_dab_x,
    output logic [15:0] o_dab_y,
    output logic [12:0] o_dab_size,
    output logic [8:0]  o_dab_alpha,
    output logic [15:0] o_dab_angle,
    output logic [15:0] o_carry_out,
    output logic        o_cut_short,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "brush_dab_placement_macros.svh"

    localparam int N_W = $clog2(MAX_DABS);
    localparam logic [N_W-1:0] N_LIM = N_W'(MAX_DABS - 1);
    localparam logic [24:0] C_MAX = 25'((64'd1 << COORD_BITS) - 64'd1);

    t_state r_state, n_state;

    // Configuration registers.
    logic [11:0] r_spacing, r_base;
    logic        r_sfp, r_afp;
    logic [15:0] r_aj;
    logic [8:0]  r_sj;

    // Segment and dab working registers.
    logic [15:0] r_sx, r_sy, r_mx, r_my;
    logic        r_negx, r_negy;
    logic [8:0]  r_pr;
    logic [18:0] r_t;
    logic [16:0] r_dist;
    logic [32:0] r_sq;
    logic [N_W-1:0] r_n;
    logic        r_cut;
    logic [12:0] r_size, n_size;
    logic [8:0]  r_alpha;
    logic [15:0] r_angle, r_px, r_py;
    logic [42:0] r_prod;

    // Output register.
    logic        r_ov, r_kind, r_ocut, r_olast;
    logic [15:0] r_ox, r_oy, r_oangle, r_ocarry;
    logic [12:0] r_osize;
    logic [8:0]  r_oalpha;

    // Shared multiplier operands and unit controls.
    logic [25:0] w_ma;
    logic [16:0] w_mb;
    logic        w_mul_en, w_adv;
    t_itu_ctl    w_ctl;
    t_itu_stat   w_stat;
    logic [16:0] w_itu_res;
    logic [15:0] w_rnd;
    logic        w_slot, w_acc_in;
    logic [16:0] w_dx, w_dy;
    logic [26:0] w_h;
    logic [16:0] w_step;
    logic [18:0] w_left;
    logic [32:0] w_rad;
    logic [34:0] w_num;

    function automatic logic [15:0] f_place(input logic [15:0] s, input logic neg,
                                            input logic [16:0] q);
        logic signed [25:0] p;
        logic [15:0] v;
        p = neg ? ($signed({10'b0, s}) - $signed({9'b0, q}))
                : ($signed({10'b0, s}) + $signed({9'b0, q}));
        if (p < 0) begin
            v = '0;
        end else if (p > $signed({1'b0, C_MAX})) begin
            v = C_MAX[15:0];
        end else begin
            v = p[15:0];
        end
        return v;
    endfunction

    bdp_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .o_next  (w_rnd)
    );

    bdp_itu u_itu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_radicand (w_rad),
        .i_num      (w_num),
        .i_den      ({r_dist, 1'b0}),
        .o_stat     (w_stat),
        .o_result   (w_itu_res)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_acc_in    = i_in_valid && o_in_ready;
    assign w_slot      = !r_ov || i_out_ready;
    assign w_dx        = {1'b0, i_end_x} - {1'b0, i_start_x};
    assign w_dy        = {1'b0, i_end_y} - {1'b0, i_start_y};
    assign w_h = 27'sd32768 + {2'b0, r_prod[24:0]} - {11'b0, r_sj, 7'b0};
    assign w_step = (r_prod[24:8] < 17'd16) ? 17'd16 : r_prod[24:8];
    assign w_left = (r_t > {2'b0, r_dist}) ? (r_t - {2'b0, r_dist}) : 19'd0;
    assign w_rad  = r_sq + r_prod[32:0];
    assign w_num  = {1'b0, r_prod[32:0], 1'b0} + {18'b0, r_dist};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= 12'd64;
            r_base    <= 12'd160;
            r_sfp     <= 1'b0;
            r_afp     <= 1'b0;
            r_aj      <= '0;
            r_sj      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPACING:   r_spacing <= i_cfg_data[11:0];
                CFG_BASE_SIZE: r_base    <= i_cfg_data[11:0];
                CFG_SIZE_PRS:  r_sfp     <= i_cfg_data[0];
                CFG_ALPHA_PRS: r_afp     <= i_cfg_data[0];
                CFG_ANG_JIT:   r_aj      <= i_cfg_data;
                CFG_SIZE_JIT:  r_sj      <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_acc_in) n_state = ST_SQX;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_SQS;
            ST_SQS:  n_state = ST_SQRT;
            ST_SQRT: begin
                if (w_stat.done) n_state = (w_itu_res == 17'd0) ? ST_IDLE : ST_CHK;
            end
            ST_CHK: begin
                if (r_t > {2'b0, r_dist} || r_n >= N_LIM) n_state = ST_FIN;
                else if (r_sfp) n_state = ST_SZP;
                else n_state = ST_JIT;
            end
            ST_SZP:  n_state = ST_JIT;
            ST_JIT:  n_state = (r_sj != 9'd0) ? ST_JH : ST_ANG;
            ST_JH:   n_state = w_h[26] ? ST_ANG : ST_JS;
            ST_JS:   n_state = ST_ANG;
            ST_ANG:  n_state = (r_aj != 16'd0) ? ST_ANGW : ST_PX;
            ST_ANGW: n_state = ST_PX;
            ST_PX:   n_state = ST_DXS;
            ST_DXS:  n_state = ST_DXW;
            ST_DXW:  if (w_stat.done) n_state = ST_PY;
            ST_PY:   n_state = ST_DYS;
            ST_DYS:  n_state = ST_DYW;
            ST_DYW:  if (w_stat.done) n_state = ST_STEP;
            ST_STEP: n_state = ST_EMIT;
            ST_EMIT: if (w_slot) n_state = ST_CHK;
            ST_FIN:  if (w_slot) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Unit controls and multiplier operands.
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b0;
        w_adv    = 1'b0;
        w_ctl    = '{start: 1'b0, op: ITU_SQRT};
        case (r_state)
            ST_SQX: begin
                w_ma = {10'b0, r_mx}; w_mb = {1'b0, r_mx}; w_mul_en = 1'b1;
            end
            ST_SQY: begin
                w_ma = {10'b0, r_my}; w_mb = {1'b0, r_my}; w_mul_en = 1'b1;
            end
            ST_SQS: w_ctl = '{start: 1'b1, op: ITU_SQRT};
            ST_CHK: begin
                w_ma = {14'b0, r_base}; w_mb = {8'b0, r_pr}; w_mul_en = 1'b1;
            end
            ST_JIT: begin
                if (r_sj != 9'd0) begin
                    w_adv = 1'b1;
                    w_ma = {10'b0, w_rnd}; w_mb = {8'b0, r_sj}; w_mul_en = 1'b1;
                end
            end
            ST_JH: begin
                w_ma = w_h[25:0]; w_mb = {4'b0, r_size}; w_mul_en = 1'b1;
            end
            ST_ANG: begin
                if (r_aj != 16'd0) begin
                    w_adv = 1'b1;
                    w_ma = {10'b0, w_rnd}; w_mb = {1'b0, r_aj}; w_mul_en = 1'b1;
                end
            end
            ST_PX: begin
                w_ma = {10'b0, r_mx}; w_mb = r_t[16:0]; w_mul_en = 1'b1;
            end
            ST_PY: begin
                w_ma = {10'b0, r_my}; w_mb = r_t[16:0]; w_mul_en = 1'b1;
            end
            ST_DXS, ST_DYS: w_ctl = '{start: 1'b1, op: ITU_DIV};
            ST_STEP: begin
                w_ma = {13'b0, r_size}; w_mb = {5'b0, r_spacing}; w_mul_en = 1'b1;
            end
            default: ;
        endcase
    end

    // Dab size update.
    always_comb begin
        n_size = r_size;
        case (r_state)
            ST_CHK: n_size = {1'b0, r_base};
            ST_SZP: n_size = (r_prod[19:8] < 12'd16) ? 13'd16 : {1'b0, r_prod[19:8]};
            ST_JH:  if (w_h[26]) n_size = '0;
            ST_JS:  n_size = (r_prod[42:15] > 28'd8191) ? 13'd8191 : r_prod[27:15];
            default: ;
        endcase
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (w_mul_en) r_prod <= w_ma * w_mb;
        r_size <= n_size;
        if (w_acc_in) begin
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_negx <= w_dx[16];
            r_negy <= w_dy[16];
            r_mx   <= w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
            r_my   <= w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
            r_pr   <= (i_pressure > 9'd256) ? 9'd256 : i_pressure;
            r_t    <= {3'b0, i_carry_in};
            r_n    <= '0;
            r_cut  <= 1'b0;
        end
        case (r_state)
            ST_SQY:  r_sq <= r_prod[32:0];
            ST_SQRT: if (w_stat.done) r_dist <= w_itu_res;
            ST_CHK: begin
                if (r_t <= {2'b0, r_dist} && r_n >= N_LIM) r_cut <= 1'b1;
                r_angle <= '0;
            end
            ST_ANG:  r_alpha <= r_afp ? r_pr : 9'd256;
            ST_ANGW: r_angle <= r_prod[31:16];
            ST_DXW:  if (w_stat.done) r_px <= f_place(r_sx, r_negx, w_itu_res);
            ST_DYW:  if (w_stat.done) r_py <= f_place(r_sy, r_negy, w_itu_res);
            ST_EMIT: begin
                if (w_slot) begin
                    r_t <= r_t + {2'b0, w_step};
                    r_n <= r_n + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == ST_EMIT || r_state == ST_FIN) && w_slot) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output payload load.
    always_ff @(posedge i_clk) begin
        if (w_slot && r_state == ST_EMIT) begin
            r_kind   <= 1'b0;
            r_ox     <= r_px;
            r_oy     <= r_py;
            r_osize  <= r_size;
            r_oalpha <= r_alpha;
            r_oangle <= r_angle;
            r_ocarry <= '0;
            r_ocut   <= 1'b0;
            r_olast  <= 1'b0;
        end else if (w_slot && r_state == ST_FIN) begin
            r_kind   <= 1'b1;
            r_ox     <= '0;
            r_oy     <= '0;
            r_osize  <= '0;
            r_oalpha <= '0;
            r_oangle <= '0;
            r_ocarry <= (w_left > 19'd65535) ? 16'hFFFF : w_left[15:0];
            r_ocut   <= r_cut;
            r_olast  <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_dab_x     = r_ox;
    assign o_dab_y     = r_oy;
    assign o_dab_size  = r_osize;
    assign o_dab_alpha = r_oalpha;
    assign o_dab_angle = r_oangle;
    assign o_carry_out = r_ocarry;
    assign o_cut_short = r_ocut;
    assign o_last      = r_olast;

    // The divider or root only finishes while the sequencer waits for it.
    `BDP_ASSERT_IMP(a_done_wait, i_clk, i_rst_n, w_stat.done, (r_state == ST_SQRT || r_state == ST_DXW || r_state == ST_DYW))
    // A dab is only emitted inside the segment.
    `BDP_ASSERT_IMP(a_emit_inside, i_clk, i_rst_n, r_state == ST_EMIT, r_t <= {2'b0, r_dist})
    // The dab count never passes the run limit.
    `BDP_ASSERT_IMP(a_count_limit, i_clk, i_rst_n, r_state != ST_IDLE && r_state != ST_SQX, r_n <= N_LIM)

endmodule

FILE: src/bdp_lfsr.sv
module bdp_lfsr import bdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    output logic [15:0] o_next
);

    logic [15:0] r_lfsr;

    // Galois step, shifting right.
    assign o_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_SEED;
        end else if (i_adv) begin
            r_lfsr <= o_next;
        end
    end

endmodule

FILE: src/bdp_itu.sv
module bdp_itu import bdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_itu_ctl    i_ctl,
    input  logic [32:0] i_radicand,
    input  logic [34:0] i_num,
    input  logic [17:0] i_den,
    output t_itu_stat   o_stat,
    output logic [16:0] o_result
);

    logic        r_busy, r_done;
    t_itu_op     r_op;
    logic [4:0]  r_cnt;
    logic [33:0] r_acc, r_res, r_bit;

    logic [33:0] w_sub_a, w_sub_b;
    logic [34:0] w_diff;
    logic        w_ge;
    logic [18:0] w_rem2;

    // One shared compare and subtract serves both operations.
    assign w_rem2 = {r_acc[17:0], r_res[16]};
    always_comb begin
        if (r_op == ITU_SQRT) begin
            w_sub_a = r_acc;
            w_sub_b = r_res + r_bit;
        end else begin
            w_sub_a = {15'b0, w_rem2};
            w_sub_b = r_bit;
        end
    end
    assign w_diff = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_ge   = ~w_diff[34];

    // Control: one result bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= ITU_LAST;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 5'd1;
            r_busy <= (r_cnt != 5'd0);
            r_done <= (r_cnt == 5'd0);
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath for root and restoring division.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op <= i_ctl.op;
            if (i_ctl.op == ITU_SQRT) begin
                r_acc <= {1'b0, i_radicand};
                r_res <= '0;
                r_bit <= 34'h1_0000_0000;
            end else begin
                r_acc <= {16'b0, i_num[34:17]};
                r_res <= {17'b0, i_num[16:0]};
                r_bit <= {16'b0, i_den};
            end
        end else if (r_busy) begin
            if (r_op == ITU_SQRT) begin
                if (w_ge) begin
                    r_acc <= w_diff[33:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                r_acc <= w_ge ? w_diff[33:0] : {15'b0, w_rem2};
                r_res <= {r_res[32:0], w_ge};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_res[16:0];

endmodule
